@@ rtl/core/rbd_pkg.sv @@
// Shared types and codes for the ring buffer double-ended queue.
package rbd_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_BACK   = 3'd0,
    KIND_ADD_FRONT  = 3'd1,
    KIND_TAKE_BACK  = 3'd2,
    KIND_TAKE_FRONT = 3'd3,
    KIND_CLEAR      = 3'd4,
    KIND_NOP        = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_IGNORED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage

@@ rtl/core/ring_buffer_deque.sv @@
// Double-ended queue kept in a ring memory with front and back pointers and a count.
// Result path: after the accepting edge the sequencer steps through ST_READ and ST_LOAD;
//   ST_LOAD loads the result register and m_tvalid rises. A new transaction is taken only
//   once the last one is loaded, set by the registered reads of the ring memory (write/pointer
//   update, read of both ends, load of the result); the load waits while a result is not taken.
// Reset (rst, synchronous, active high) clears pointers, count, state and m_tvalid;
//   the ring memory keeps its contents and needs no clearing pass.
module ring_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // slave side
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // s_tdata: value
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
  // s_tuser: kind
  input  logic [rbd_pkg::KIND_W-1:0]              s_tuser,
  // master side
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // m_tdata: front_value, back_value, count, empty, is_full, status
  output logic [((2*DATA_WIDTH+$clog2(DEPTH+1)+4+7)/8)*8-1:0] m_tdata
);
  import rbd_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OUT_W = ((2*DATA_WIDTH + CW + 4 + 7) / 8) * 8;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Ring memory: one write port, two registered read ports.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_back;

  // Control state.
  state_t        state, state_next;
  logic [AW-1:0] front_index, front_index_next;
  logic [AW-1:0] back_index, back_index_next;
  logic [CW-1:0] entry_count, entry_count_next;
  status_t       status, status_next;

  // Memory write request, issued in the cycle a transaction is accepted.
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // Result register: parts the master side from the queue logic.
  logic [DATA_WIDTH-1:0] out_front;
  logic [DATA_WIDTH-1:0] out_back;
  logic [CW-1:0]         out_count;
  logic                  out_empty;
  logic                  out_full;
  status_t               out_status;
  logic                  load;

  logic                  accept;
  logic [AW-1:0]         back_last;
  logic [AW-1:0]         front_dec;
  logic                  is_full_now;
  logic                  queue_empty;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  assign accept       = s_tvalid && s_tready;
  assign is_full_now  = (entry_count == FULL_CNT);
  assign queue_empty  = (entry_count == '0);
  assign front_dec    = slot_dec(front_index);
  // back_index points one past the back entry; read the slot before it.
  assign back_last    = slot_dec(back_index);

  // Sequencer: accept, then read both ends, then load the result register.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // Hold until the result register is free or being drained.
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Pointer, count and status update for the accepted request.
  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    entry_count_next = entry_count;
    status_next      = status;
    wr_en            = 1'b0;
    wr_addr          = back_index;
    wr_data          = s_tdata[DATA_WIDTH-1:0];
    if (accept) begin
      status_next = STAT_DONE;
      case (kind_t'(s_tuser))
        KIND_ADD_BACK: begin
          if (is_full_now) begin
            status_next = STAT_REJECTED;
          end else begin
            wr_en            = 1'b1;
            wr_addr          = back_index;
            back_index_next  = slot_inc(back_index);
            entry_count_next = entry_count + CW'(1);
          end
        end
        KIND_ADD_FRONT: begin
          if (is_full_now) begin
            status_next = STAT_REJECTED;
          end else begin
            wr_en            = 1'b1;
            wr_addr          = front_dec;
            front_index_next = front_dec;
            entry_count_next = entry_count + CW'(1);
          end
        end
        KIND_TAKE_BACK: begin
          if (queue_empty) begin
            status_next = STAT_IGNORED;
          end else begin
            back_index_next  = back_last;
            entry_count_next = entry_count - CW'(1);
          end
        end
        KIND_TAKE_FRONT: begin
          if (queue_empty) begin
            status_next = STAT_IGNORED;
          end else begin
            front_index_next = slot_inc(front_index);
            entry_count_next = entry_count - CW'(1);
          end
        end
        KIND_CLEAR: begin
          front_index_next = '0;
          back_index_next  = '0;
          entry_count_next = '0;
        end
        default: begin
          // No-op and unused codes leave the queue as it is.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      back_index  <= '0;
      entry_count <= '0;
      status      <= STAT_DONE;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      back_index  <= back_index_next;
      entry_count <= entry_count_next;
      status      <= status_next;
    end
  end

  // Write lands at the accept edge; the reads in the next cycle see it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_front <= mem[front_index];
    rd_back  <= mem[back_last];
  end

  // Result register; ends read as zero while the queue is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_front  <= queue_empty ? '0 : rd_front;
      out_back   <= queue_empty ? '0 : rd_back;
      out_count  <= entry_count;
      out_empty  <= queue_empty;
      out_full   <= is_full_now;
      out_status <= status;
    end
  end

  assign m_tdata = OUT_W'({out_status, out_full, out_empty, out_count, out_back, out_front});

`ifndef SYNTHESIS
  // Count never runs past capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count exceeds capacity");

  // Back pointer sits count slots after the front pointer, modulo the ring.
  a_ptr_relation: assert property (@(posedge clk) disable iff (rst)
    ((32'(front_index) + 32'(entry_count)) == 32'(back_index)) ||
    ((32'(front_index) + 32'(entry_count)) == (32'(back_index) + 32'(DEPTH))))
    else $error("front/back pointers disagree with count");

  // An accepted transaction always moves on to the read step.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_READ))
    else $error("accepted transaction did not start a read");

  // A loaded result carries consistent empty and count fields.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule
